/* design/tcfa_pkg.sv */
// tcfa_pkg: shared types and constants of the touch contact frame assembler
// no dependencies; imported by every module of the block
package tcfa_pkg;

    localparam int SLOT_W = 5;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_X_LOW      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_X_HIGH     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_Y_LOW      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_Y_HIGH     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_VALUE_BITS = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_MS = 3'd5;

    localparam logic [1:0] KIND_CONTACT   = 2'd0;
    localparam logic [1:0] KIND_FRAME_END = 2'd1;
    localparam logic [1:0] KIND_CANCEL    = 2'd2;
    localparam logic [1:0] KIND_BAD_COUNT = 2'd3;

    typedef enum logic [1:0] {
        CMD_EMIT  = 2'd0,
        CMD_STORE = 2'd1,
        CMD_FLUSH = 2'd2
    } cmd_op_t;

    typedef struct packed {
        logic signed [31:0] x_low;
        logic signed [31:0] x_high;
        logic signed [31:0] y_low;
        logic signed [31:0] y_high;
        logic [5:0]         value_bits;
        logic [15:0]        timeout_ms;
    } cfg_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [1:0]        kind;
        logic              last;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        id;
        logic              active;
        logic [31:0]       x_raw;
        logic [31:0]       y_raw;
    } cmd_t;

    function automatic cmd_t mk_emit(logic [1:0] kind);
        cmd_t c;
        c = '0;
        c.op = CMD_EMIT;
        c.kind = kind;
        return c;
    endfunction

endpackage

/* design/touch_contact_frame_assembler.sv */
// touch_contact_frame_assembler: top level, configuration registers, front,
// command queue and back; depends on tcfa_pkg, tcfa_front, tcfa_queue, tcfa_back
//
//   channel   ports                        handshake
//   input     s_op .. s_confidence         s_valid / s_ready
//   result    m_kind .. m_last             m_valid / m_ready
//   config    cfg_wr_index, cfg_wr_data    cfg_wr_en, no wait
//
// the front takes an item, then passes its commands (up to three) to the queue before the next
// a stored contact holds the back through pop, clamp check, 16 divide steps, write-back
// a frame walk visits one pending entry a cycle while output is free, then sends the frame end
// the queue and the result register let the front keep working while a result waits
// reset is synchronous; no clearing pass
module touch_contact_frame_assembler import tcfa_pkg::*; #(
    parameter int MAX_CONTACTS = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_wr_index,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_op,
    input  logic                 s_report_first,
    input  logic                 s_has_slot,
    input  logic [7:0]           s_contact_count,
    input  logic [15:0]          s_scan_time,
    input  logic [31:0]          s_now_ms,
    input  logic                 s_slot_ok,
    input  logic [7:0]           s_contact_id,
    input  logic [31:0]          s_x_raw,
    input  logic [31:0]          s_y_raw,
    input  logic                 s_tip,
    input  logic                 s_confidence,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_kind,
    output logic [7:0]           m_contact_id_res,
    output logic [15:0]          m_x_norm,
    output logic [15:0]          m_y_norm,
    output logic                 m_last
);

    cfg_t cfg_reg;
    logic fq_valid, fq_ready, bq_valid, bq_ready;
    cmd_t fq_data, bq_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_low <= 32'sd0;
            cfg_reg.x_high <= 32'sd4095;
            cfg_reg.y_low <= 32'sd0;
            cfg_reg.y_high <= 32'sd4095;
            cfg_reg.value_bits <= 6'd16;
            cfg_reg.timeout_ms <= 16'd100;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_X_LOW:      cfg_reg.x_low <= cfg_wr_data;
                REG_X_HIGH:     cfg_reg.x_high <= cfg_wr_data;
                REG_Y_LOW:      cfg_reg.y_low <= cfg_wr_data;
                REG_Y_HIGH:     cfg_reg.y_high <= cfg_wr_data;
                REG_VALUE_BITS: cfg_reg.value_bits <= cfg_wr_data[5:0];
                REG_TIMEOUT_MS: cfg_reg.timeout_ms <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    tcfa_front #(.MAX_CONTACTS(MAX_CONTACTS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_report_first(s_report_first), .s_has_slot(s_has_slot),
        .s_contact_count(s_contact_count), .s_scan_time(s_scan_time),
        .s_now_ms(s_now_ms), .s_slot_ok(s_slot_ok), .s_contact_id(s_contact_id),
        .s_x_raw(s_x_raw), .s_y_raw(s_y_raw), .s_tip(s_tip),
        .s_confidence(s_confidence),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    tcfa_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
        .out_valid(bq_valid), .out_ready(bq_ready), .out_data(bq_data)
    );

    tcfa_back #(.MAX_CONTACTS(MAX_CONTACTS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_contact_id_res(m_contact_id_res), .m_x_norm(m_x_norm),
        .m_y_norm(m_y_norm), .m_last(m_last)
    );

endmodule

/* design/tcfa_norm.sv */
// tcfa_norm: coordinate normalizer, sign extension, clamping and a
// bit-serial rounded division to unsigned Q0.16; uses tcfa_pkg
module tcfa_norm import tcfa_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [31:0]        raw,
    input  logic signed [31:0] lo,
    input  logic signed [31:0] hi,
    input  logic [5:0]         value_bits,
    output logic               busy,
    output logic [15:0]        res
);

    typedef enum logic [2:0] {
        N_IDLE = 3'b001,
        N_PREP = 3'b010,
        N_DIV  = 3'b100
    } nstate_t;

    nstate_t            state_reg, state_next;
    logic signed [34:0] num_reg, num_next;
    logic signed [33:0] den_reg, den_next;
    logic [31:0]        dv_reg, dv_next;
    logic [31:0]        rem_reg, rem_next;
    logic [15:0]        low_reg, low_next;
    logic [15:0]        q_reg, q_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [15:0]        res_reg, res_next;

    logic [33:0] sbit;
    logic [33:0] v;
    logic [47:0] dividend;
    logic [32:0] r2;

    assign busy = (state_reg != N_IDLE);
    assign res  = res_reg;

    always_comb begin
        sbit = 34'd1 << (value_bits - 6'd1);
        if (lo[31] && value_bits >= 6'd1 && value_bits <= 6'd32) begin
            v = ({2'b00, raw} ^ sbit) - sbit;
        end else begin
            v = {2'b00, raw};
        end
        dividend = {num_reg[31:0], 16'd0} - {16'd0, num_reg[31:0]}
                 + {17'd0, den_reg[31:1]};
        r2 = {rem_reg, low_reg[15]};
    end

    always_comb begin
        state_next = state_reg;
        num_next = num_reg;
        den_next = den_reg;
        dv_next = dv_reg;
        rem_next = rem_reg;
        low_next = low_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        res_next = res_reg;
        case (state_reg)
            N_IDLE: begin
                if (start) begin
                    num_next = $signed({v[33], v}) - $signed({{3{lo[31]}}, lo});
                    den_next = $signed({{2{hi[31]}}, hi}) - $signed({{2{lo[31]}}, lo});
                    state_next = N_PREP;
                end
            end
            N_PREP: begin
                if (den_reg <= 34'sd0 || num_reg <= 35'sd0) begin
                    res_next = 16'd0;
                    state_next = N_IDLE;
                end else if (num_reg >= $signed({den_reg[33], den_reg})) begin
                    res_next = 16'hffff;
                    state_next = N_IDLE;
                end else begin
                    rem_next = dividend[47:16];
                    low_next = dividend[15:0];
                    dv_next = den_reg[31:0];
                    q_next = 16'd0;
                    cnt_next = 4'd0;
                    state_next = N_DIV;
                end
            end
            N_DIV: begin
                if (r2 >= {1'b0, dv_reg}) begin
                    rem_next = 32'(r2 - {1'b0, dv_reg});
                    q_next = {q_reg[14:0], 1'b1};
                end else begin
                    rem_next = r2[31:0];
                    q_next = {q_reg[14:0], 1'b0};
                end
                low_next = {low_reg[14:0], 1'b0};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    res_next = q_next;
                    state_next = N_IDLE;
                end
            end
            default: state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
        end else begin
            state_reg <= state_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        dv_reg <= dv_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg <= q_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

endmodule

/* design/tcfa_queue.sv */
// tcfa_queue: short command queue between front and back
// uses cmd_t and the depth constants of tcfa_pkg
module tcfa_queue import tcfa_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_data
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push, pop;

    assign in_ready  = (count_reg != (QPTR_W + 1)'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            mem_reg[wr_reg] <= in_data;
        end
    end

endmodule

/* design/tcfa_front.sv */
// tcfa_front: accepts slots, runs the frame bookkeeping and issues commands
// uses tcfa_pkg; feeds tcfa_queue
module tcfa_front import tcfa_pkg::*; #(
    parameter int MAX_CONTACTS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic        s_report_first,
    input  logic        s_has_slot,
    input  logic [7:0]  s_contact_count,
    input  logic [15:0] s_scan_time,
    input  logic [31:0] s_now_ms,
    input  logic        s_slot_ok,
    input  logic [7:0]  s_contact_id,
    input  logic [31:0] s_x_raw,
    input  logic [31:0] s_y_raw,
    input  logic        s_tip,
    input  logic        s_confidence,
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_data
);

    localparam int CW = $clog2(MAX_CONTACTS + 1);
    localparam int IW = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;

    logic [7:0]    ids_reg [MAX_CONTACTS];
    logic [7:0]    ids_next [MAX_CONTACTS];
    logic [CW-1:0] pcount_reg, pcount_next;
    logic [CW-1:0] ecount_reg, ecount_next;
    logic [15:0]   scan_reg, scan_next;
    logic [31:0]   time_reg, time_next;
    logic          skip_reg, skip_next;
    cmd_t          cmds_reg [3];
    cmd_t          cmds_next [3];
    logic [1:0]    left_reg, left_next;

    cmd_t          lst [3];
    logic [1:0]    n;
    logic          go, bad, dup, found;
    logic [1:0]    lastpos;
    logic          accept;
    logic [31:0]   gap;

    assign s_ready = (left_reg == 2'd0);
    assign accept  = s_valid && s_ready;
    assign q_valid = (left_reg != 2'd0);
    assign q_data  = cmds_reg[0];
    assign gap     = s_now_ms - time_reg;

    always_comb begin
        ids_next = ids_reg;
        pcount_next = pcount_reg;
        ecount_next = ecount_reg;
        scan_next = scan_reg;
        time_next = time_reg;
        skip_next = skip_reg;
        cmds_next = cmds_reg;
        left_next = left_reg;
        lst[0] = '0;
        lst[1] = '0;
        lst[2] = '0;
        n = 2'd0;
        go = 1'b1;
        bad = 1'b0;
        dup = 1'b0;
        found = 1'b0;
        lastpos = 2'd0;

        if (q_valid && q_ready) begin
            cmds_next[0] = cmds_reg[1];
            cmds_next[1] = cmds_reg[2];
            left_next = left_reg - 2'd1;
        end

        if (accept) begin
            if (s_op) begin
                lst[n] = mk_emit(KIND_CANCEL);
                n = n + 2'd1;
                pcount_next = '0;
                ecount_next = '0;
                skip_next = 1'b1;
            end else begin
                if (s_report_first) begin
                    skip_next = 1'b0;
                    if (s_contact_count > 8'(MAX_CONTACTS)) begin
                        lst[n] = mk_emit(KIND_CANCEL);
                        n = n + 2'd1;
                        lst[n] = mk_emit(KIND_BAD_COUNT);
                        n = n + 2'd1;
                        pcount_next = '0;
                        ecount_next = '0;
                        skip_next = 1'b1;
                        go = 1'b0;
                    end else begin
                        if (ecount_next != '0 && (s_scan_time != scan_reg
                                || gap > {16'd0, cfg.timeout_ms})) begin
                            lst[n] = mk_emit(KIND_CANCEL);
                            n = n + 2'd1;
                            pcount_next = '0;
                            ecount_next = '0;
                        end
                        time_next = s_now_ms;
                        if (s_contact_count != 8'd0) begin
                            if (ecount_next != '0) begin
                                lst[n] = mk_emit(KIND_CANCEL);
                                n = n + 2'd1;
                            end
                            pcount_next = '0;
                            ecount_next = CW'(s_contact_count);
                            scan_next = s_scan_time;
                        end else if (ecount_next == '0) begin
                            lst[n] = mk_emit(KIND_FRAME_END);
                            n = n + 2'd1;
                            skip_next = 1'b1;
                            go = 1'b0;
                        end
                    end
                end
                if (go && s_has_slot && !skip_next && pcount_next < ecount_next) begin
                    for (int i = 0; i < MAX_CONTACTS; i++) begin
                        if (CW'(i) < pcount_next && ids_reg[i] == s_contact_id) begin
                            dup = 1'b1;
                        end
                    end
                    bad = !s_slot_ok || (cfg.x_high <= cfg.x_low)
                        || (cfg.y_high <= cfg.y_low) || dup;
                    if (bad) begin
                        lst[n] = mk_emit(KIND_CANCEL);
                        n = n + 2'd1;
                        pcount_next = '0;
                        ecount_next = '0;
                        skip_next = 1'b1;
                    end else begin
                        lst[n] = '0;
                        lst[n].op = CMD_STORE;
                        lst[n].slot = SLOT_W'(pcount_next);
                        lst[n].id = s_contact_id;
                        lst[n].active = s_tip && s_confidence;
                        lst[n].x_raw = s_x_raw;
                        lst[n].y_raw = s_y_raw;
                        n = n + 2'd1;
                        ids_next[pcount_next[IW-1:0]] = s_contact_id;
                        pcount_next = pcount_next + 1'b1;
                        if (pcount_next == ecount_next) begin
                            lst[n] = '0;
                            lst[n].op = CMD_FLUSH;
                            lst[n].slot = SLOT_W'(pcount_next);
                            n = n + 2'd1;
                            pcount_next = '0;
                            ecount_next = '0;
                            skip_next = 1'b1;
                        end
                    end
                end
            end
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < n && lst[i].op != CMD_STORE) begin
                    found = 1'b1;
                    lastpos = 2'(i);
                end
            end
            if (found) begin
                lst[lastpos].last = 1'b1;
            end
            cmds_next = lst;
            left_next = n;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcount_reg <= '0;
            ecount_reg <= '0;
            scan_reg <= '0;
            time_reg <= '0;
            skip_reg <= 1'b0;
            left_reg <= 2'd0;
        end else begin
            pcount_reg <= pcount_next;
            ecount_reg <= ecount_next;
            scan_reg <= scan_next;
            time_reg <= time_next;
            skip_reg <= skip_next;
            left_reg <= left_next;
        end
        ids_reg <= ids_next;
        cmds_reg <= cmds_next;
    end

endmodule

/* design/tcfa_back.sv */
// tcfa_back: executes queued commands, holds pending contacts, walks frames
// uses tcfa_pkg and two tcfa_norm units
module tcfa_back import tcfa_pkg::*; #(
    parameter int MAX_CONTACTS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        q_valid,
    output logic        q_ready,
    input  cmd_t        q_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_contact_id_res,
    output logic [15:0] m_x_norm,
    output logic [15:0] m_y_norm,
    output logic        m_last
);

    localparam int CW = $clog2(MAX_CONTACTS + 1);
    localparam int IW = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_NORM  = 3'b010,
        B_FLUSH = 3'b100
    } bstate_t;

    bstate_t       state_reg, state_next;
    logic [7:0]    id_mem [MAX_CONTACTS];
    logic [15:0]   x_mem [MAX_CONTACTS];
    logic [15:0]   y_mem [MAX_CONTACTS];
    logic          act_mem [MAX_CONTACTS];
    logic [IW-1:0] slot_reg;
    logic [CW-1:0] walk_reg, walk_next;
    logic [CW-1:0] total_reg;
    logic          flast_reg;

    logic          m_valid_reg;
    logic [1:0]    kind_reg, kind_next;
    logic [7:0]    id_reg, id_next;
    logic [15:0]   xo_reg, xo_next;
    logic [15:0]   yo_reg, yo_next;
    logic          last_reg, last_next;
    logic          load_out, out_free;

    logic          start, store_pop, flush_pop;
    logic          x_busy, y_busy;
    logic [15:0]   x_res, y_res;
    logic [IW-1:0] wi;

    assign out_free = !m_valid_reg || m_ready;
    assign wi = walk_reg[IW-1:0];
    assign m_valid = m_valid_reg;
    assign m_kind = kind_reg;
    assign m_contact_id_res = id_reg;
    assign m_x_norm = xo_reg;
    assign m_y_norm = yo_reg;
    assign m_last = last_reg;

    tcfa_norm u_norm_x (
        .aclk(aclk), .aresetn(aresetn), .start(start), .raw(q_data.x_raw),
        .lo(cfg.x_low), .hi(cfg.x_high), .value_bits(cfg.value_bits),
        .busy(x_busy), .res(x_res)
    );

    tcfa_norm u_norm_y (
        .aclk(aclk), .aresetn(aresetn), .start(start), .raw(q_data.y_raw),
        .lo(cfg.y_low), .hi(cfg.y_high), .value_bits(cfg.value_bits),
        .busy(y_busy), .res(y_res)
    );

    always_comb begin
        state_next = state_reg;
        walk_next = walk_reg;
        q_ready = 1'b0;
        load_out = 1'b0;
        kind_next = kind_reg;
        id_next = id_reg;
        xo_next = xo_reg;
        yo_next = yo_reg;
        last_next = last_reg;
        start = 1'b0;
        store_pop = 1'b0;
        flush_pop = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    case (q_data.op)
                        CMD_EMIT: begin
                            if (out_free) begin
                                q_ready = 1'b1;
                                load_out = 1'b1;
                                kind_next = q_data.kind;
                                id_next = 8'd0;
                                xo_next = 16'd0;
                                yo_next = 16'd0;
                                last_next = q_data.last;
                            end
                        end
                        CMD_STORE: begin
                            q_ready = 1'b1;
                            start = 1'b1;
                            store_pop = 1'b1;
                            state_next = B_NORM;
                        end
                        CMD_FLUSH: begin
                            q_ready = 1'b1;
                            flush_pop = 1'b1;
                            walk_next = '0;
                            state_next = B_FLUSH;
                        end
                        default: q_ready = 1'b1;
                    endcase
                end
            end
            B_NORM: begin
                if (!x_busy && !y_busy) begin
                    state_next = B_IDLE;
                end
            end
            B_FLUSH: begin
                if (walk_reg < total_reg) begin
                    if (act_mem[wi]) begin
                        if (out_free) begin
                            load_out = 1'b1;
                            kind_next = KIND_CONTACT;
                            id_next = id_mem[wi];
                            xo_next = x_mem[wi];
                            yo_next = y_mem[wi];
                            last_next = 1'b0;
                            walk_next = walk_reg + 1'b1;
                        end
                    end else begin
                        walk_next = walk_reg + 1'b1;
                    end
                end else if (out_free) begin
                    load_out = 1'b1;
                    kind_next = KIND_FRAME_END;
                    id_next = 8'd0;
                    xo_next = 16'd0;
                    yo_next = 16'd0;
                    last_next = flast_reg;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        walk_reg <= walk_next;
        kind_reg <= kind_next;
        id_reg <= id_next;
        xo_reg <= xo_next;
        yo_reg <= yo_next;
        last_reg <= last_next;
        if (store_pop) begin
            slot_reg <= q_data.slot[IW-1:0];
            id_mem[q_data.slot[IW-1:0]] <= q_data.id;
            act_mem[q_data.slot[IW-1:0]] <= q_data.active;
        end
        if (flush_pop) begin
            total_reg <= q_data.slot[CW-1:0];
            flast_reg <= q_data.last;
        end
        if (state_reg == B_NORM && !x_busy && !y_busy) begin
            x_mem[slot_reg] <= x_res;
            y_mem[slot_reg] <= y_res;
        end
    end

endmodule

/* tb/tb_touch_contact_frame_assembler.sv */
// testbench for touch_contact_frame_assembler: directed and random report streams
// checked against an in-bench frame predictor; depends on tcfa_pkg and the block
module tb_touch_contact_frame_assembler;
    import tcfa_pkg::*;

    localparam int MAXC = 5;

    typedef struct packed {
        logic        op;
        logic        report_first;
        logic        has_slot;
        logic [7:0]  contact_count;
        logic [15:0] scan_time;
        logic [31:0] now_ms;
        logic        slot_ok;
        logic [7:0]  contact_id;
        logic [31:0] x_raw;
        logic [31:0] y_raw;
        logic        tip;
        logic        confidence;
    } slot_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  id;
        logic [15:0] xn;
        logic [15:0] yn;
        logic        last;
    } frame_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_wr_index = '0;
    logic [31:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    slot_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_kind;
    logic [7:0] m_contact_id_res;
    logic [15:0] m_x_norm, m_y_norm;
    logic m_last;

    touch_contact_frame_assembler dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_op(s_item.op), .s_report_first(s_item.report_first),
        .s_has_slot(s_item.has_slot), .s_contact_count(s_item.contact_count),
        .s_scan_time(s_item.scan_time), .s_now_ms(s_item.now_ms),
        .s_slot_ok(s_item.slot_ok), .s_contact_id(s_item.contact_id),
        .s_x_raw(s_item.x_raw), .s_y_raw(s_item.y_raw),
        .s_tip(s_item.tip), .s_confidence(s_item.confidence),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_contact_id_res(m_contact_id_res), .m_x_norm(m_x_norm),
        .m_y_norm(m_y_norm), .m_last(m_last)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // predictor state
    logic signed [31:0] c_xlo = 0, c_xhi = 4095, c_ylo = 0, c_yhi = 4095;
    logic [5:0] c_vbits = 16;
    logic [15:0] c_tmo = 100;
    logic [7:0] f_ids [MAXC];
    logic [15:0] f_x [MAXC], f_y [MAXC];
    logic f_act [MAXC];
    int unsigned f_pend = 0, f_exp = 0;
    logic [15:0] f_scan = 0;
    logic [31:0] f_tlast = 0;
    bit f_skip = 0;

    slot_item_t pending_slots[$];
    frame_res_t expected_res[$];
    int errors = 0, n_res = 0, n_sent = 0, cycles = 0;
    bit quiet = 0, hold_long = 0;

    function automatic void enqueue_slot(slot_item_t it);
        pending_slots.insert(pending_slots.size(), it);
    endfunction

    task automatic report(input string what, input frame_res_t got, input frame_res_t want);
        errors++;
        $display("mismatch %s: got k%0d id%0d x%0d y%0d l%0d want k%0d id%0d x%0d y%0d l%0d",
            what, got.kind, got.id, got.xn, got.yn, got.last,
            want.kind, want.id, want.xn, want.yn, want.last);
    endtask

    function automatic logic [15:0] scale_coord(logic [31:0] raw, logic signed [31:0] lo,
                                                logic signed [31:0] hi);
        longint v, s, num, den;
        v = longint'(raw);
        if (lo < 0 && c_vbits >= 1 && c_vbits <= 32) begin
            s = longint'(1) << (c_vbits - 1);
            v = (v ^ s) - s;
        end
        num = v - longint'(lo);
        den = longint'(hi) - longint'(lo);
        if (den <= 0 || num <= 0) return 16'd0;
        if (num >= den) return 16'hffff;
        return 16'((num * 65535 + den / 2) / den);
    endfunction

    function automatic void push_res(ref frame_res_t r[$], input logic [1:0] k,
                                     input logic [7:0] id, input logic [15:0] x, y);
        frame_res_t e;
        e = '{kind: k, id: id, xn: x, yn: y, last: 1'b0};
        r.insert(r.size(), e);
    endfunction

    function automatic void drop_frame(ref frame_res_t r[$]);
        f_pend = 0;
        f_exp = 0;
        push_res(r, KIND_CANCEL, 0, 0, 0);
    endfunction

    function automatic void predict_frame(slot_item_t it);
        frame_res_t r[$];
        bit go, dup;
        go = 1;
        if (it.op) begin
            drop_frame(r);
            f_skip = 1;
        end else begin
            if (it.report_first) begin
                f_skip = 0;
                if (it.contact_count > MAXC) begin
                    drop_frame(r);
                    push_res(r, KIND_BAD_COUNT, 0, 0, 0);
                    f_skip = 1;
                    go = 0;
                end else begin
                    if (f_exp != 0 && (it.scan_time != f_scan ||
                        (it.now_ms - f_tlast) > {16'd0, c_tmo}))
                        drop_frame(r);
                    f_tlast = it.now_ms;
                    if (it.contact_count > 0) begin
                        if (f_exp != 0) drop_frame(r);
                        f_pend = 0;
                        f_exp = it.contact_count;
                        f_scan = it.scan_time;
                    end else if (f_exp == 0) begin
                        push_res(r, KIND_FRAME_END, 0, 0, 0);
                        f_skip = 1;
                        go = 0;
                    end
                end
            end
            if (go && it.has_slot && !f_skip && f_pend < f_exp) begin
                dup = 0;
                for (int i = 0; i < f_pend; i++)
                    if (f_ids[i] == it.contact_id) dup = 1;
                if (!it.slot_ok || c_xhi <= c_xlo || c_yhi <= c_ylo || dup) begin
                    f_skip = 1;
                    drop_frame(r);
                end else if (f_pend < MAXC) begin
                    f_ids[f_pend] = it.contact_id;
                    f_x[f_pend] = scale_coord(it.x_raw, c_xlo, c_xhi);
                    f_y[f_pend] = scale_coord(it.y_raw, c_ylo, c_yhi);
                    f_act[f_pend] = it.tip & it.confidence;
                    f_pend++;
                    if (f_pend == f_exp) begin
                        for (int i = 0; i < f_pend; i++)
                            if (f_act[i]) push_res(r, KIND_CONTACT, f_ids[i], f_x[i], f_y[i]);
                        push_res(r, KIND_FRAME_END, 0, 0, 0);
                        f_pend = 0;
                        f_exp = 0;
                        f_skip = 1;
                    end
                end
            end
        end
        if (r.size() > 0) r[r.size()-1].last = 1'b1;
        foreach (r[i]) expected_res.insert(expected_res.size(), r[i]);
    endfunction

    // driver
    int s_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_frame(s_item);
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_slots.size() > 0) begin
                    s_item <= pending_slots.pop_front();
                    s_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 5) == 0) s_gap <= $urandom_range(1, 11);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stalls
    int m_gap = 0, long_hold = 0;
    always @(posedge aclk) begin
        if (hold_long && long_hold == 0) long_hold <= 300;
        if (long_hold > 1) begin
            long_hold <= long_hold - 1;
            m_ready <= 1'b0;
        end else if (long_hold == 1) begin
            long_hold <= 0;
            m_ready <= 1'b1;
        end else if (m_gap > 0) begin
            m_gap <= m_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 6) == 0) m_gap <= $urandom_range(1, 11);
        end
    end

    // monitor
    always @(posedge aclk) begin
        frame_res_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{kind: m_kind, id: m_contact_id_res, xn: m_x_norm, yn: m_y_norm,
                    last: m_last};
            n_res++;
            if (expected_res.size() == 0) begin
                report("unexpected transfer", got, '0);
            end else begin
                want = expected_res.pop_front();
                if (got.kind != want.kind) report("kind", got, want);
                else if (got.id != want.id) report("id", got, want);
                else if (got.xn != want.xn) report("x_norm", got, want);
                else if (got.yn != want.yn) report("y_norm", got, want);
                else if (got.last != want.last) report("last", got, want);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // stimulus helpers
    logic [31:0] clock_ms = 1000;
    logic [15:0] scan_now = 1;

    function automatic slot_item_t mk_slot(bit first, bit hs, int cnt, logic [7:0] id);
        slot_item_t it;
        it = '0;
        it.report_first = first;
        it.has_slot = hs;
        it.contact_count = 8'(cnt);
        it.scan_time = scan_now;
        it.now_ms = clock_ms;
        it.slot_ok = 1;
        it.contact_id = id;
        it.x_raw = $urandom_range(0, 4200);
        it.y_raw = $urandom_range(0, 4200);
        it.tip = 1;
        it.confidence = 1;
        return it;
    endfunction

    task automatic add_frame(int cnt, bit split, bit noisy);
        slot_item_t it;
        logic [7:0] base;
        base = 8'($urandom_range(0, 250));
        scan_now = scan_now + 16'($urandom_range(1, 30));
        clock_ms = clock_ms + $urandom_range(0, 20);
        for (int i = 0; i < cnt; i++) begin
            it = mk_slot(i == 0 || (split && i == 2), 1, i == 0 ? cnt : 0, base + 8'(i));
            if (split && i == 2) clock_ms = clock_ms + $urandom_range(0, 40);
            it.now_ms = clock_ms;
            it.tip = $urandom_range(0, 3) != 0;
            it.confidence = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 3) == 0) begin
                it.x_raw = $urandom;
                it.y_raw = $urandom;
            end
            if (noisy) begin
                case ($urandom_range(0, 5))
                    0: it.slot_ok = 0;
                    1: it.contact_id = base;
                    2: it.scan_time = 16'($urandom);
                    3: it.now_ms = clock_ms + $urandom_range(90, 70000);
                    4: it.op = 1;
                    default: it.contact_count = 8'($urandom);
                endcase
            end
            enqueue_slot(it);
        end
    endtask

    task automatic wait_drained();
        while (pending_slots.size() > 0 || s_valid || expected_res.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_X_LOW: c_xlo = val;
            REG_X_HIGH: c_xhi = val;
            REG_Y_LOW: c_ylo = val;
            REG_Y_HIGH: c_yhi = val;
            REG_VALUE_BITS: c_vbits = val[5:0];
            REG_TIMEOUT_MS: c_tmo = val[15:0];
            default: ;
        endcase
    endtask

    task automatic random_phase(int frames);
        for (int f = 0; f < frames; f++) begin
            if ($urandom_range(0, 4) == 0) begin
                slot_item_t it;
                logic [159:0] rbits;
                rbits = {$urandom, $urandom, $urandom, $urandom, $urandom};
                it = rbits[$bits(slot_item_t)-1:0];
                it.contact_count = $urandom_range(0, 1) ? 8'($urandom_range(0, 7))
                                                        : 8'($urandom);
                enqueue_slot(it);
            end else begin
                add_frame($urandom_range(1, MAXC), $urandom_range(0, 1),
                          $urandom_range(0, 4) == 0);
            end
        end
    endtask

    initial begin
        slot_item_t it;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty report, bad count, cancel, full frame, duplicate, timeout
        enqueue_slot(mk_slot(1, 0, 0, 0));
        enqueue_slot(mk_slot(1, 1, 255, 1));
        enqueue_slot(mk_slot(1, 1, 6, 1));
        it = mk_slot(0, 1, 0, 0); it.op = 1; enqueue_slot(it);
        add_frame(MAXC, 1, 0);
        it = mk_slot(1, 1, 3, 7); enqueue_slot(it);
        it = mk_slot(0, 1, 0, 7); enqueue_slot(it);
        it = mk_slot(1, 1, 2, 9); enqueue_slot(it);
        it = mk_slot(1, 1, 0, 10); it.now_ms = clock_ms + 5000; enqueue_slot(it);
        it = mk_slot(1, 1, 2, 11); it.x_raw = '1; it.y_raw = 0; enqueue_slot(it);
        it = mk_slot(0, 1, 0, 12); it.slot_ok = 0; enqueue_slot(it);
        it = mk_slot(1, 1, 1, 13); it.tip = 0; enqueue_slot(it);
        it = mk_slot(0, 1, 0, 14); enqueue_slot(it);
        wait_drained();

        // receiver holds off while frames keep coming
        hold_long = 1;
        wait (long_hold != 0);
        hold_long = 0;
        random_phase(16);
        wait_drained();

        write_reg(REG_X_LOW, 32'hffff_f000);
        write_reg(REG_X_HIGH, 32'h0000_0fff);
        write_reg(REG_Y_LOW, 32'h8000_0000);
        write_reg(REG_Y_HIGH, 32'h7fff_ffff);
        write_reg(REG_VALUE_BITS, 13);
        write_reg(REG_TIMEOUT_MS, 0);
        random_phase(26);
        wait_drained();

        write_reg(REG_VALUE_BITS, 32);
        write_reg(REG_TIMEOUT_MS, 16'hffff);
        write_reg(REG_X_LOW, 100);
        write_reg(REG_X_HIGH, 100);
        random_phase(10);
        wait_drained();

        write_reg(REG_VALUE_BITS, 1);
        write_reg(REG_X_LOW, 32'hffff_ffff);
        write_reg(REG_X_HIGH, 0);
        write_reg(REG_TIMEOUT_MS, 60);
        random_phase(26);
        wait_drained();

        write_reg(REG_VALUE_BITS, 0);
        write_reg(REG_X_LOW, 0);
        write_reg(REG_X_HIGH, 4095);
        write_reg(REG_Y_LOW, 0);
        write_reg(REG_Y_HIGH, 4095);
        quiet = 1;
        random_phase(20);
        wait_drained();

        $display("%0d slot items sent, %0d results checked over five register settings",
                 n_sent, n_res);
        if (errors == 0 && expected_res.size() == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
